@@ rtl/mpdm_pkg.sv @@
// Package for the Modbus PWM duty master: sizes, codes, command/status structs
// and the CRC-16/Modbus byte step.
// No dependencies.
package mpdm_pkg;

    localparam int MAX_CHANNELS   = 8;
    localparam int REPLY_BYTES    = 8;
    localparam int MAX_REGISTERS  = 16;
    localparam int REGS_PER_CH    = 3;
    localparam int CC_LIMIT_RAW   = MAX_REGISTERS / REGS_PER_CH;
    localparam int CC_LIMIT       = (CC_LIMIT_RAW < MAX_CHANNELS) ? CC_LIMIT_RAW : MAX_CHANNELS;
    localparam int CH_W           = $clog2(MAX_CHANNELS);
    localparam int RCNT_W         = $clog2(REPLY_BYTES + 1);
    localparam int MIN_REPLY      = 5;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  FUNC_WRITE = 8'h10;
    localparam logic [15:0] WAIT_SAT   = 16'hFFFF;
    localparam logic [6:0]  FREQ_SCALE = 7'd100;

    // request types
    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_OFF  = 2'd1;
    localparam logic [1:0] REQ_RX   = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CH   = 3'd1;
    localparam logic [2:0] ST_BAD_DUTY = 3'd2;
    localparam logic [2:0] ST_FAILED   = 3'd3;
    localparam logic [2:0] ST_BUSY     = 3'd4;

    // fail reasons
    localparam logic [2:0] FR_NONE     = 3'd0;
    localparam logic [2:0] FR_NO_REPLY = 3'd1;
    localparam logic [2:0] FR_SHORT    = 3'd2;
    localparam logic [2:0] FR_CRC      = 3'd3;
    localparam logic [2:0] FR_ID       = 3'd4;
    localparam logic [2:0] FR_EXCEPT   = 3'd5;
    localparam logic [2:0] FR_FUNC     = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_DEVICE_ID = 3'd0;
    localparam logic [2:0] CFG_REG_BASE  = 3'd1;
    localparam logic [2:0] CFG_FREQ_HZ   = 3'd2;
    localparam logic [2:0] CFG_CH_COUNT  = 3'd3;
    localparam logic [2:0] CFG_DUTY_MAX  = 3'd4;
    localparam logic [2:0] CFG_DUTY_OFF  = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd6;

    // frame phases
    localparam logic [1:0] PH_HDR  = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    typedef struct packed {
        logic       load_status;
        logic [2:0] status;
        logic       use_judge;
        logic       store_duty;
        logic       all_off;
        logic       frame_start;
        logic       emit;
        logic [1:0] phase;
        logic       rx_take;
        logic       tick_take;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic chan_bad;
        logic duty_bad;
        logic cc_bad;
        logic cc_zero;
        logic idx_last;
        logic ch_last;
        logic rx_full;
        logic tick_due;
    } t_stat;

    // one byte through CRC-16/Modbus, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/mpdm_ifs.sv @@
// Handshake interfaces for the request and result channels.
// Depends on nothing.
interface mpdm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [2:0]  channel;
    logic [15:0] duty;
    logic [7:0]  rx_byte;
    modport source (output valid, req_type, channel, duty, rx_byte, input ready);
    modport sink   (input valid, req_type, channel, duty, rx_byte, output ready);
endinterface

interface mpdm_res_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic [2:0] status;
    logic [2:0] fail_reason;
    modport source (output valid, out_kind, tx_byte, last_of_run, status, fail_reason,
                    input ready);
    modport sink   (input valid, out_kind, tx_byte, last_of_run, status, fail_reason,
                    output ready);
endinterface

@@ rtl/modbus_pwm_duty_master_top.sv @@
// Top level of the Modbus PWM duty master: controller plus datapath.
// Depends on mpdm_pkg, mpdm_ifs, mpdm_ctrl and mpdm_dp.
//
//  channel   dir  handshake      carries
//  i_req     in   valid/ready    req_type, channel, duty, rx_byte
//  o_res     out  valid/ready    out_kind, tx_byte, last_of_run, status, fail_reason
//  i_cfg_*   in   write enable   register index, data
//
// A request that sends a frame gives one frame byte per cycle while the result is
// taken: 9 + 6 * channel_count bytes, set by the sequencer. Requests are taken only
// between frames and while the result register is free.
// Reset is synchronous, active low; duties return to zero and settings to defaults.
module modbus_pwm_duty_master_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [25:0] i_cfg_data,
    mpdm_req_if.sink    i_req,
    mpdm_res_if.source  o_res
);
    import mpdm_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ready;

    assign i_req.ready = ready;

    mpdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_stat     (stat),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    mpdm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_channel     (i_req.channel),
        .i_duty        (i_req.duty),
        .i_rx_byte     (i_req.rx_byte),
        .i_cmd         (cmd),
        .i_out_ready   (o_res.ready),
        .o_stat        (stat),
        .o_out_valid   (o_res.valid),
        .o_out_kind    (o_res.out_kind),
        .o_tx_byte     (o_res.tx_byte),
        .o_last_of_run (o_res.last_of_run),
        .o_status      (o_res.status),
        .o_fail_reason (o_res.fail_reason)
    );

endmodule

@@ rtl/mpdm_ctrl.sv @@
// Controller for the Modbus PWM duty master: request decode and frame sequencing.
// Depends on mpdm_pkg.
module mpdm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_req_type,
    input  mpdm_pkg::t_stat i_stat,
    output logic           o_ready,
    output mpdm_pkg::t_cmd o_cmd
);
    import mpdm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WAIT = 3'd1;
    localparam logic [2:0] S_HDR  = 3'd2;
    localparam logic [2:0] S_BODY = 3'd3;
    localparam logic [2:0] S_CRC  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       acc;

    assign o_ready = ((r_state == S_IDLE) || (r_state == S_WAIT)) && i_stat.out_free;
    assign acc     = o_ready && i_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc && (i_req_type == REQ_SET)) begin
                    if (i_stat.chan_bad) begin
                        o_cmd.load_status = 1'b1;
                        o_cmd.status      = ST_BAD_CH;
                    end else if (i_stat.duty_bad) begin
                        o_cmd.load_status = 1'b1;
                        o_cmd.status      = ST_BAD_DUTY;
                    end else begin
                        o_cmd.store_duty = 1'b1;
                        if (i_stat.cc_bad) begin
                            o_cmd.load_status = 1'b1;
                            o_cmd.status      = ST_BAD_CH;
                        end else begin
                            o_cmd.frame_start = 1'b1;
                            n_state           = S_HDR;
                        end
                    end
                end else if (acc && (i_req_type == REQ_OFF)) begin
                    o_cmd.all_off = 1'b1;
                    if (i_stat.cc_bad) begin
                        o_cmd.load_status = 1'b1;
                        o_cmd.status      = ST_BAD_CH;
                    end else begin
                        o_cmd.frame_start = 1'b1;
                        n_state           = S_HDR;
                    end
                end
            end
            S_WAIT: begin
                if (acc && ((i_req_type == REQ_SET) || (i_req_type == REQ_OFF))) begin
                    o_cmd.load_status = 1'b1;
                    o_cmd.status      = ST_BUSY;
                end else if (acc && (i_req_type == REQ_RX)) begin
                    o_cmd.rx_take = 1'b1;
                    if (i_stat.rx_full) begin
                        o_cmd.load_status = 1'b1;
                        o_cmd.use_judge   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (acc && (i_req_type == REQ_TICK)) begin
                    o_cmd.tick_take = 1'b1;
                    if (i_stat.tick_due) begin
                        o_cmd.load_status = 1'b1;
                        o_cmd.use_judge   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_HDR: begin
                o_cmd.phase = PH_HDR;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = i_stat.cc_zero ? S_CRC : S_BODY;
                    end
                end
            end
            S_BODY: begin
                o_cmd.phase = PH_BODY;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.idx_last && i_stat.ch_last) begin
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                o_cmd.phase = PH_CRC;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_WAIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/mpdm_dp.sv @@
// Datapath for the Modbus PWM duty master: settings, duty store, frame bytes,
// frame CRC, reply capture and judging, result register.
// Depends on mpdm_pkg.
module mpdm_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [25:0]     i_cfg_data,
    input  logic [2:0]      i_channel,
    input  logic [15:0]     i_duty,
    input  logic [7:0]      i_rx_byte,
    input  mpdm_pkg::t_cmd  i_cmd,
    input  logic            i_out_ready,
    output mpdm_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output logic            o_out_kind,
    output logic [7:0]      o_tx_byte,
    output logic            o_last_of_run,
    output logic [2:0]      o_status,
    output logic [2:0]      o_fail_reason
);
    import mpdm_pkg::*;

    // settings
    logic [7:0]  r_dev_id;
    logic [15:0] r_reg_base;
    logic [25:0] r_freq;
    logic [3:0]  r_cc;
    logic [15:0] r_duty_max;
    logic [15:0] r_duty_off;
    logic [15:0] r_timeout;

    logic [15:0] r_duty [MAX_CHANNELS];

    // frame state
    logic [31:0]     r_fv;
    logic [2:0]      r_idx;
    logic [CH_W-1:0] r_ch;
    logic [15:0]     r_crc;

    // reply state
    logic [RCNT_W-1:0] r_rcnt;
    logic [7:0]        r_b0, r_b1, r_d0, r_d1;
    logic [15:0]       r_rcrc;
    logic [15:0]       r_wait;

    // result register
    logic       r_ov;
    logic       r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic [2:0] r_st;
    logic [2:0] r_fr;

    logic [7:0]        regs;
    logic [7:0]        hdr_byte, body_byte, crc_out_byte, frame_byte;
    logic [15:0]       duty_cur;
    logic [15:0]       n_wait;
    logic [15:0]       rcrc_step;
    logic [RCNT_W-1:0] j_n;
    logic [15:0]       j_got, j_crc;
    logic [2:0]        j_fr;
    logic [31:0]       fv_calc;

    assign regs     = {4'd0, r_cc} * 8'(REGS_PER_CH);
    assign duty_cur = r_duty[r_ch];
    assign fv_calc  = 32'({6'd0, r_freq} * {25'd0, FREQ_SCALE});

    // header byte select
    always_comb begin
        case (r_idx)
            3'd0:    hdr_byte = r_dev_id;
            3'd1:    hdr_byte = FUNC_WRITE;
            3'd2:    hdr_byte = r_reg_base[15:8];
            3'd3:    hdr_byte = r_reg_base[7:0];
            3'd4:    hdr_byte = 8'd0;
            3'd5:    hdr_byte = regs;
            default: hdr_byte = {regs[6:0], 1'b0};
        endcase
    end

    // per-channel bytes: frequency word pair then duty
    always_comb begin
        case (r_idx)
            3'd0:    body_byte = r_fv[31:24];
            3'd1:    body_byte = r_fv[23:16];
            3'd2:    body_byte = r_fv[15:8];
            3'd3:    body_byte = r_fv[7:0];
            3'd4:    body_byte = duty_cur[15:8];
            default: body_byte = duty_cur[7:0];
        endcase
    end

    assign crc_out_byte = r_idx[0] ? r_crc[15:8] : r_crc[7:0];

    always_comb begin
        case (i_cmd.phase)
            PH_HDR:  frame_byte = hdr_byte;
            PH_BODY: frame_byte = body_byte;
            default: frame_byte = crc_out_byte;
        endcase
    end

    // reply judging, either on the byte that fills the buffer or on timeout
    assign rcrc_step = crc_byte(r_rcrc, r_d1);
    assign n_wait    = (r_wait != WAIT_SAT) ? (r_wait + 16'd1) : r_wait;

    always_comb begin
        if (i_cmd.rx_take) begin
            j_n   = RCNT_W'(REPLY_BYTES);
            j_got = {i_rx_byte, r_d0};
            j_crc = rcrc_step;
        end else begin
            j_n   = r_rcnt;
            j_got = {r_d0, r_d1};
            j_crc = r_rcrc;
        end
        if (j_n == '0) begin
            j_fr = FR_NO_REPLY;
        end else if (j_n < RCNT_W'(MIN_REPLY)) begin
            j_fr = FR_SHORT;
        end else if (j_crc != j_got) begin
            j_fr = FR_CRC;
        end else if (r_b0 != r_dev_id) begin
            j_fr = FR_ID;
        end else if (r_b1[7]) begin
            j_fr = FR_EXCEPT;
        end else if (r_b1 != FUNC_WRITE) begin
            j_fr = FR_FUNC;
        end else begin
            j_fr = FR_NONE;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.out_free = !r_ov || i_out_ready;
        o_stat.chan_bad = ({1'b0, i_channel} >= r_cc);
        o_stat.duty_bad = (i_duty > r_duty_max);
        o_stat.cc_bad   = (r_cc > 4'(CC_LIMIT));
        o_stat.cc_zero  = (r_cc == 4'd0);
        o_stat.ch_last  = ({1'b0, r_ch} == (r_cc - 4'd1));
        o_stat.rx_full  = (r_rcnt == RCNT_W'(REPLY_BYTES - 1));
        o_stat.tick_due = (n_wait >= r_timeout);
        case (i_cmd.phase)
            PH_HDR:  o_stat.idx_last = (r_idx == 3'd6);
            PH_BODY: o_stat.idx_last = (r_idx == 3'd5);
            default: o_stat.idx_last = (r_idx == 3'd1);
        endcase
    end

    // settings and duty store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id   <= 8'd1;
            r_reg_base <= 16'd0;
            r_freq     <= 26'd1000;
            r_cc       <= 4'd4;
            r_duty_max <= 16'd1000;
            r_duty_off <= 16'd0;
            r_timeout  <= 16'd500;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_duty[i] <= 16'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEVICE_ID: r_dev_id   <= i_cfg_data[7:0];
                    CFG_REG_BASE:  r_reg_base <= i_cfg_data[15:0];
                    CFG_FREQ_HZ:   r_freq     <= i_cfg_data;
                    CFG_CH_COUNT:  r_cc       <= i_cfg_data[3:0];
                    CFG_DUTY_MAX:  r_duty_max <= i_cfg_data[15:0];
                    CFG_DUTY_OFF:  r_duty_off <= i_cfg_data[15:0];
                    CFG_TIMEOUT:   r_timeout  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.store_duty) begin
                r_duty[i_channel[CH_W-1:0]] <= i_duty;
            end
            if (i_cmd.all_off) begin
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    r_duty[i] <= r_duty_off;
                end
            end
        end
    end

    // frame counters and running CRC
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_start) begin
            r_fv  <= fv_calc;
            r_idx <= 3'd0;
            r_ch  <= '0;
            r_crc <= CRC_INIT;
        end else if (i_cmd.emit) begin
            if (i_cmd.phase != PH_CRC) begin
                r_crc <= crc_byte(r_crc, frame_byte);
            end
            if (o_stat.idx_last) begin
                r_idx <= 3'd0;
                if (i_cmd.phase == PH_BODY) begin
                    r_ch <= r_ch + CH_W'(1);
                end
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // reply capture: CRC runs two bytes behind the newest one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt <= '0;
            r_wait <= 16'd0;
        end else if (i_cmd.frame_start) begin
            r_rcnt <= '0;
            r_wait <= 16'd0;
        end else begin
            if (i_cmd.rx_take) begin
                r_rcnt <= r_rcnt + RCNT_W'(1);
            end
            if (i_cmd.tick_take) begin
                r_wait <= n_wait;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_start) begin
            r_rcrc <= CRC_INIT;
        end else if (i_cmd.rx_take) begin
            if (r_rcnt == '0) begin
                r_b0 <= i_rx_byte;
            end
            if (r_rcnt == RCNT_W'(1)) begin
                r_b1 <= i_rx_byte;
            end
            if (r_rcnt >= RCNT_W'(2)) begin
                r_rcrc <= rcrc_step;
            end
            r_d1 <= r_d0;
            r_d0 <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_status || i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_status) begin
            r_kind <= KIND_STATUS;
            r_byte <= 8'd0;
            r_last <= 1'b1;
            if (i_cmd.use_judge) begin
                r_st <= (j_fr == FR_NONE) ? ST_OK : ST_FAILED;
                r_fr <= j_fr;
            end else begin
                r_st <= i_cmd.status;
                r_fr <= FR_NONE;
            end
        end else if (i_cmd.emit) begin
            r_kind <= KIND_BYTE;
            r_byte <= frame_byte;
            r_last <= (i_cmd.phase == PH_CRC) && o_stat.idx_last;
            r_st   <= ST_OK;
            r_fr   <= FR_NONE;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_kind    = r_kind;
    assign o_tx_byte     = r_byte;
    assign o_last_of_run = r_last;
    assign o_status      = r_st;
    assign o_fail_reason = r_fr;

endmodule

@@ rtl/mpdm_chk.sv @@
// Port-level checks for the Modbus PWM duty master, bound to the top level.
// Depends on mpdm_pkg and modbus_pwm_duty_master_top.
module mpdm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_kind,
    input logic [7:0] i_tx_byte,
    input logic       i_last,
    input logic [2:0] i_status,
    input logic [2:0] i_reason
);
    import mpdm_pkg::*;

    // no request taken while a result is stuck
    a_no_accept_when_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("request taken while result stalled");

    // status items close a run and carry no byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == KIND_STATUS)) |-> (i_last && (i_tx_byte == 8'd0)))
        else $error("status item malformed");

    // frame bytes carry no status
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == KIND_BYTE)) |-> ((i_status == ST_OK)
            && (i_reason == FR_NONE)))
        else $error("frame byte with status");

    // a reason only with a failed write
    a_reason_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_reason != FR_NONE)) |-> (i_status == ST_FAILED))
        else $error("reason without failure");

    // nothing pending just after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind modbus_pwm_duty_master_top mpdm_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.out_kind),
    .i_tx_byte   (o_res.tx_byte),
    .i_last      (o_res.last_of_run),
    .i_status    (o_res.status),
    .i_reason    (o_res.fail_reason)
);

@@ tb/sv/mpdm_checker.sv @@
// Checker for the Modbus PWM duty master: watches both channels and the
// configuration port, predicts each result item and compares field by field.
// Depends on mpdm_pkg and mpdm_ifs.
module mpdm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [25:0] i_cfg_data,
    mpdm_req_if         req,
    mpdm_res_if         res,
    output int          o_errors,
    output int          o_pending,
    output int          o_res_seen
);
    import mpdm_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] txb;
        logic       last;
        logic [2:0] st;
        logic [2:0] why;
    } t_res_item;

    t_res_item expected_q[$];

    // shadow settings and state
    logic [7:0]  dev_id;
    logic [15:0] reg_base;
    logic [25:0] freq;
    logic [3:0]  ch_count;
    logic [15:0] duty_lim;
    logic [15:0] duty_idle;
    logic [15:0] tmo;
    logic [15:0] duties[MAX_CHANNELS];
    logic [7:0]  rx_buf[REPLY_BYTES];
    int          rx_n;
    logic        waiting;
    logic [15:0] ticks;

    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    task automatic push_status(input logic [2:0] st, input logic [2:0] why);
        expected_q.push_back('{KIND_STATUS, 8'h00, 1'b1, st, why});
    endtask

    // frame for current duties, or a refusal
    task automatic predict_frame();
        logic [7:0]  fr[$];
        logic [31:0] fv;
        logic [15:0] crc;
        int          regs;
        if (ch_count > MAX_CHANNELS || ch_count * 3 > MAX_REGISTERS) begin
            push_status(ST_BAD_CH, FR_NONE);
            return;
        end
        regs = ch_count * 3;
        fv = 32'(64'(freq) * 100);
        fr = '{dev_id, FUNC_WRITE, reg_base[15:8], reg_base[7:0], 8'h00, 8'(regs),
               8'(regs * 2)};
        for (int i = 0; i < ch_count; i++) begin
            fr.push_back(fv[31:24]); fr.push_back(fv[23:16]);
            fr.push_back(fv[15:8]);  fr.push_back(fv[7:0]);
            fr.push_back(duties[i][15:8]); fr.push_back(duties[i][7:0]);
        end
        crc = CRC_INIT;
        foreach (fr[i]) crc = crc_step(crc, fr[i]);
        fr.push_back(crc[7:0]); fr.push_back(crc[15:8]);
        foreach (fr[i])
            expected_q.push_back('{KIND_BYTE, fr[i], 1'(i == fr.size() - 1), ST_OK, FR_NONE});
        waiting = 1'b1; rx_n = 0; ticks = 0;
    endtask

    task automatic judge_reply();
        logic [15:0] crc;
        waiting = 1'b0; ticks = 0;
        if (rx_n == 0) begin push_status(ST_FAILED, FR_NO_REPLY); return; end
        if (rx_n < MIN_REPLY) begin push_status(ST_FAILED, FR_SHORT); return; end
        crc = CRC_INIT;
        for (int i = 0; i < rx_n - 2; i++) crc = crc_step(crc, rx_buf[i]);
        if (crc != {rx_buf[rx_n-1], rx_buf[rx_n-2]}) push_status(ST_FAILED, FR_CRC);
        else if (rx_buf[0] != dev_id) push_status(ST_FAILED, FR_ID);
        else if (rx_buf[1][7]) push_status(ST_FAILED, FR_EXCEPT);
        else if (rx_buf[1] != FUNC_WRITE) push_status(ST_FAILED, FR_FUNC);
        else push_status(ST_OK, FR_NONE);
    endtask

    task automatic predict_request(input logic [1:0] rt, input logic [2:0] ch,
                                   input logic [15:0] d, input logic [7:0] b);
        case (rt)
            REQ_SET: begin
                if (waiting) push_status(ST_BUSY, FR_NONE);
                else if (ch >= ch_count) push_status(ST_BAD_CH, FR_NONE);
                else if (d > duty_lim) push_status(ST_BAD_DUTY, FR_NONE);
                else begin
                    duties[ch] = d;
                    predict_frame();
                end
            end
            REQ_OFF: begin
                if (waiting) push_status(ST_BUSY, FR_NONE);
                else begin
                    foreach (duties[i]) duties[i] = duty_idle;
                    predict_frame();
                end
            end
            REQ_RX: begin
                if (waiting) begin
                    if (rx_n < REPLY_BYTES) begin rx_buf[rx_n] = b; rx_n++; end
                    if (rx_n >= REPLY_BYTES) judge_reply();
                end
            end
            default: begin
                if (waiting) begin
                    if (ticks != WAIT_SAT) ticks++;
                    if (ticks >= tmo) judge_reply();
                end
            end
        endcase
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_res_item got, exp_item;
        if (!i_rst_n) begin
            dev_id <= 8'd1; reg_base <= '0; freq <= 26'd1000; ch_count <= 4'd4;
            duty_lim <= 16'd1000; duty_idle <= '0; tmo <= 16'd500;
            foreach (duties[i]) duties[i] = '0;
            rx_n = 0; waiting = 1'b0; ticks = 0;
            expected_q.delete();
            o_errors <= 0; o_res_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEVICE_ID: dev_id    <= i_cfg_data[7:0];
                    CFG_REG_BASE:  reg_base  <= i_cfg_data[15:0];
                    CFG_FREQ_HZ:   freq      <= i_cfg_data;
                    CFG_CH_COUNT:  ch_count  <= i_cfg_data[3:0];
                    CFG_DUTY_MAX:  duty_lim  <= i_cfg_data[15:0];
                    CFG_DUTY_OFF:  duty_idle <= i_cfg_data[15:0];
                    CFG_TIMEOUT:   tmo       <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                predict_request(req.req_type, req.channel, req.duty, req.rx_byte);
            // compare the result item
            if (res.valid && res.ready) begin
                got = '{res.out_kind, res.tx_byte, res.last_of_run, res.status,
                        res.fail_reason};
                o_res_seen <= o_res_seen + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result item %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (got !== exp_item) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p, got %p", exp_item, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the Modbus PWM duty master: clock, reset, configuration,
// request stimulus, receiver stalls and verdict. Depends on mpdm_pkg, mpdm_ifs,
// mpdm_checker and the block itself.
module tb;
    import mpdm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [25:0] cfg_data = '0;
    int          errors, pending, res_seen;
    int          idle_cycles = 0;
    int          items_sent = 0;
    bit          long_hold = 1'b0;
    bit          hold_done = 1'b0;

    mpdm_req_if req();
    mpdm_res_if res();

    always #5 i_clk = ~i_clk;

    modbus_pwm_duty_master_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_req(req), .o_res(res)
    );

    mpdm_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .req(req), .res(res), .o_errors(errors),
        .o_pending(pending), .o_res_seen(res_seen)
    );

    initial begin
        req.valid = 1'b0; req.req_type = REQ_TICK; req.channel = '0;
        req.duty = '0; req.rx_byte = '0;
        res.ready = 1'b0;
    end

    // receiver stalls on its own pattern, with one long hold-off
    always @(negedge i_clk) begin
        if (long_hold) res.ready <= 1'b0;
        else if (items_sent % 200 < 60) res.ready <= 1'b1;
        else res.ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || long_hold)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [25:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // one request item, held until taken
    task automatic send_req(input logic [1:0] rt, input logic [2:0] ch,
                            input logic [15:0] d, input logic [7:0] b);
        req.valid <= 1'b1; req.req_type <= rt; req.channel <= ch;
        req.duty <= d; req.rx_byte <= b;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // reply of given shape: 0 good, 1 bad crc, 2 wrong id, 3 exception, 4 wrong func
    task automatic send_reply(input logic [7:0] id, input int shape, input int len);
        logic [7:0]  r[$];
        logic [15:0] c;
        r = '{id, FUNC_WRITE};
        if (shape == 2) r[0] = id ^ 8'h01;
        if (shape == 3) r[1] = 8'h90;
        if (shape == 4) r[1] = 8'h03;
        while (r.size() < len - 2) r.push_back(8'($urandom));
        c = 16'hFFFF;
        foreach (r[i]) begin
            c = c ^ r[i];
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        if (shape == 1) c = ~c;
        r.push_back(c[7:0]); r.push_back(c[15:8]);
        foreach (r[i]) begin send_req(REQ_RX, 3'($urandom), 16'($urandom), r[i]); gap(); end
    endtask

    task automatic ticks_out(input int n);
        repeat (n) begin send_req(REQ_TICK, 3'($urandom), 16'($urandom), 8'($urandom)); gap(); end
    endtask

    logic [7:0] cur_id;
    int         tmo;
    int         cc;

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        cur_id = 8'd1;
        @(negedge i_clk);

        // directed: defaults, bad channel, bad duty, busy, idle bytes and ticks
        send_req(REQ_RX, 3'd7, 16'hFFFF, 8'hFF);
        send_req(REQ_TICK, 3'd0, 16'h0, 8'h00);
        send_req(REQ_SET, 3'd4, 16'd5, 8'h00);
        send_req(REQ_SET, 3'd7, 16'hFFFF, 8'h00);
        send_req(REQ_SET, 3'd1, 16'd1001, 8'h00);
        send_req(REQ_SET, 3'd3, 16'd1000, 8'h00);
        send_req(REQ_SET, 3'd0, 16'd0, 8'h00);
        send_req(REQ_OFF, 3'd0, 16'd0, 8'h00);
        send_reply(cur_id, 0, 8);
        wait_idle();
        cfg_write(CFG_TIMEOUT, 26'd1);
        send_req(REQ_OFF, 3'd0, 16'd0, 8'h00);
        ticks_out(1);
        wait_idle();
        cfg_write(CFG_TIMEOUT, 26'd3);
        for (int s = 0; s < 5; s++) begin
            send_req(REQ_SET, 3'd2, 16'd7, 8'h00);
            if (s == 0) send_reply(cur_id, 0, 3);
            else send_reply(cur_id, s, 6);
            ticks_out(3);
            wait_idle();
        end
        // settings extremes and zero or too many channels
        cfg_write(CFG_CH_COUNT, 26'd0);
        send_req(REQ_SET, 3'd0, 16'd0, 8'h00);
        send_req(REQ_OFF, 3'd0, 16'd0, 8'h00);
        ticks_out(3);
        wait_idle();
        cfg_write(CFG_CH_COUNT, 26'd8);
        send_req(REQ_SET, 3'd7, 16'd9, 8'h00);
        send_req(REQ_OFF, 3'd0, 16'd0, 8'h00);
        wait_idle();
        cfg_write(CFG_CH_COUNT, 26'd15);
        send_req(REQ_SET, 3'd6, 16'd9, 8'h00);
        wait_idle();

        // random phases through several settings
        for (int ph = 0; ph < 8; ph++) begin
            cur_id = (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom);
            cc = (ph < 2) ? 5 : $urandom_range(1, 5);
            tmo = $urandom_range(1, 12);
            cfg_write(CFG_DEVICE_ID, 26'(cur_id));
            cfg_write(CFG_REG_BASE, (ph == 1) ? 26'hFFFF : 26'($urandom_range(0, 65535)));
            cfg_write(CFG_FREQ_HZ, (ph == 1) ? 26'h3FFFFFF : (ph == 0) ? 26'd0 : 26'($urandom));
            cfg_write(CFG_CH_COUNT, 26'(cc));
            cfg_write(CFG_DUTY_MAX, (ph == 1) ? 26'hFFFF : (ph == 0) ? 26'd0
                                               : 26'($urandom_range(0, 65535)));
            cfg_write(CFG_DUTY_OFF, (ph == 1) ? 26'hFFFF : 26'($urandom_range(0, 65535)));
            cfg_write(CFG_TIMEOUT, (ph == 1) ? 26'hFFFF : 26'(tmo));
            if (ph == 1) tmo = 65535;
            for (int k = 0; k < 4; k++) begin
                int pick;
                pick = $urandom_range(0, 9);
                if (ph == 3 && k == 2 && !hold_done) begin
                    long_hold = 1'b1;
                    fork
                        begin repeat (300) @(negedge i_clk); long_hold = 1'b0; end
                    join_none
                    hold_done = 1'b1;
                end
                if (pick < 6)
                    send_req(REQ_SET, 3'($urandom_range(0, 7)),
                             ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                             16'($urandom_range(0, 1000)), 8'($urandom));
                else if (pick < 8) send_req(REQ_OFF, 3'($urandom), 16'($urandom), 8'($urandom));
                else begin send_reply(cur_id, $urandom_range(0, 4), 8); continue; end
                gap();
                // answer or provoke busy / timeout
                case ($urandom_range(0, 5))
                    0: send_req(REQ_SET, 3'($urandom), 16'($urandom), 8'($urandom));
                    1: ticks_out((tmo > 20) ? 3 : tmo);
                    2: send_reply(cur_id, 0, $urandom_range(1, 7));
                    default: send_reply(cur_id, ($urandom_range(0, 2) == 0) ?
                                        $urandom_range(1, 4) : 0, 8);
                endcase
                if (tmo <= 20) ticks_out(tmo);
                else send_reply(cur_id, 0, 8);
            end
            wait_idle();
        end

        wait_idle();
        $display("covered %0d request items and %0d result items over eight settings",
                 items_sent, res_seen);
        $display("including bad channel, bad duty, busy, timeouts and every reply fault");
        if (errors == 0 && pending == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
